@@ sv/fwrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrm_pkg
// Shared sizes, codes and controller/datapath interface types for the
// FIFO with running maximum.
// ----------------------------------------------------------------------------
package fwrm_pkg;

    localparam int DEPTH  = 256;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // out stack entry: element and running max of it and all below
    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] rmax;
    } ent_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic move_rd;
        logic move_wr;
        logic pop;
        logic refresh;
        logic result_ld;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  empty;
        logic  in_empty;
        logic  out_empty;
        logic  out_many;
        logic  out_free;
    } stat_t;

    function automatic logic signed [DATA_W-1:0] smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

@@ sv/fifo_with_running_max.sv @@
`timescale 1ns / 1ps
// Push, clear, query and full/empty words pass from accept through the decode and result states.
// Pop from a non-empty out stack also passes the pop state, and the refresh state when a new top is read back.
// Pop with an empty out stack first moves each in-stack element over (one read, one write per element).
// The next word is accepted while a finished result still waits in the output register.
// Reset (rst_n low, asynchronous) empties both stacks; stack memories are not cleared.
// ----------------------------------------------------------------------------
// fifo_with_running_max
// Signed FIFO built from two stacks with running maxima; each result gives
// the front or popped value, the queue maximum, the count and a status.
// ----------------------------------------------------------------------------
module fifo_with_running_max (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic signed [fwrm_pkg::DATA_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fwrm_pkg::DATA_W-1:0]   head_value,
    output logic signed [fwrm_pkg::DATA_W-1:0]   max_value,
    output logic [fwrm_pkg::CNT_W-1:0]           count,
    output logic [1:0]                           status
);

    fwrm_pkg::cmd_t  cmd;
    fwrm_pkg::stat_t stat;

    fwrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fwrm_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head_value (head_value),
        .max_value  (max_value),
        .count      (count),
        .status     (status)
    );

endmodule

@@ sv/fwrm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrm_ctrl
// Sequencer: decodes each word, runs the stack transfer and pop refresh,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module fwrm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fwrm_pkg::stat_t  stat,
    output fwrm_pkg::cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_MOVE_RD = 7'b0000100,
        S_MOVE_WR = 7'b0001000,
        S_POP     = 7'b0010000,
        S_REFRESH = 7'b0100000,
        S_RESULT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.exec = 1'b1;
                if (stat.mode == fwrm_pkg::MODE_POP && !stat.empty)
                begin
                    state_next = stat.out_empty ? S_MOVE_RD : S_POP;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_MOVE_RD:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                // in count was already decremented by the read step
                cmd.move_wr = 1'b1;
                state_next  = stat.in_empty ? S_POP : S_MOVE_RD;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = stat.out_many ? S_REFRESH : S_RESULT;
            end
            S_REFRESH:
            begin
                cmd.refresh = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result_ld = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/fwrm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrm_datapath
// Two stacks in memory, their counts, cached top entries and the output
// register.
// ----------------------------------------------------------------------------
module fwrm_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fwrm_pkg::cmd_t                       cmd,
    output fwrm_pkg::stat_t                      stat,
    input  logic [1:0]                           mode,
    input  logic signed [fwrm_pkg::DATA_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fwrm_pkg::DATA_W-1:0]   head_value,
    output logic signed [fwrm_pkg::DATA_W-1:0]   max_value,
    output logic [fwrm_pkg::CNT_W-1:0]           count,
    output logic [1:0]                           status
);

    localparam logic signed [fwrm_pkg::DATA_W-1:0] NONE = '1;   // -1

    // stack memories
    logic signed [fwrm_pkg::DATA_W-1:0] in_mem  [fwrm_pkg::DEPTH];
    fwrm_pkg::ent_t                     out_mem [fwrm_pkg::DEPTH];

    // latched word
    fwrm_pkg::mode_t                    mode_reg;
    logic signed [fwrm_pkg::DATA_W-1:0] value_reg;

    logic [fwrm_pkg::CNT_W-1:0] in_count_reg,  in_count_next;
    logic [fwrm_pkg::CNT_W-1:0] out_count_reg, out_count_next;

    // cached tops: in-stack running max and bottom, out-stack top entry
    logic signed [fwrm_pkg::DATA_W-1:0] in_top_max_reg,  in_top_max_next;
    logic signed [fwrm_pkg::DATA_W-1:0] in_bot_val_reg,  in_bot_val_next;
    logic signed [fwrm_pkg::DATA_W-1:0] out_top_val_reg, out_top_val_next;
    logic signed [fwrm_pkg::DATA_W-1:0] out_top_max_reg, out_top_max_next;

    logic signed [fwrm_pkg::DATA_W-1:0] head_reg, head_next;
    logic                               head_set_reg, head_set_next;
    fwrm_pkg::status_t                  status_reg, status_next;

    logic signed [fwrm_pkg::DATA_W-1:0] in_rd_reg;
    fwrm_pkg::ent_t                     out_rd_reg;

    logic                               out_valid_reg, out_valid_next;
    logic signed [fwrm_pkg::DATA_W-1:0] head_value_reg;
    logic signed [fwrm_pkg::DATA_W-1:0] max_value_reg;
    logic [fwrm_pkg::CNT_W-1:0]         count_reg;
    logic [1:0]                         status_out_reg;

    logic [fwrm_pkg::CNT_W-1:0]         total;
    logic [fwrm_pkg::CNT_W-1:0]         in_dec;
    logic [fwrm_pkg::CNT_W-1:0]         out_dec2;
    logic                               in_empty;
    logic                               out_empty;
    logic                               full;
    logic                               in_wr_en;
    logic                               out_wr_en;
    fwrm_pkg::ent_t                     out_wr_data;
    logic signed [fwrm_pkg::DATA_W-1:0] front;
    logic signed [fwrm_pkg::DATA_W-1:0] qmax;

    assign total     = in_count_reg + out_count_reg;
    assign in_dec    = in_count_reg - fwrm_pkg::CNT_W'(1);
    assign out_dec2  = out_count_reg - fwrm_pkg::CNT_W'(2);
    assign in_empty  = (in_count_reg == '0);
    assign out_empty = (out_count_reg == '0);
    assign full      = (total >= fwrm_pkg::CNT_W'(fwrm_pkg::DEPTH));

    assign stat.mode      = mode_reg;
    assign stat.empty     = (total == '0);
    assign stat.in_empty  = in_empty;
    assign stat.out_empty = out_empty;
    assign stat.out_many  = (out_count_reg > fwrm_pkg::CNT_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (!out_empty)
        begin
            front = out_top_val_reg;
        end
        else if (!in_empty)
        begin
            front = in_bot_val_reg;
        end
        else
        begin
            front = NONE;
        end

        if (!in_empty && !out_empty)
        begin
            qmax = fwrm_pkg::smax(in_top_max_reg, out_top_max_reg);
        end
        else if (!in_empty)
        begin
            qmax = in_top_max_reg;
        end
        else if (!out_empty)
        begin
            qmax = out_top_max_reg;
        end
        else
        begin
            qmax = NONE;
        end
    end

    always_comb
    begin
        in_count_next    = in_count_reg;
        out_count_next   = out_count_reg;
        in_top_max_next  = in_top_max_reg;
        in_bot_val_next  = in_bot_val_reg;
        out_top_val_next = out_top_val_reg;
        out_top_max_next = out_top_max_reg;
        head_next        = head_reg;
        head_set_next    = head_set_reg;
        status_next      = status_reg;
        in_wr_en         = 1'b0;
        out_wr_en        = 1'b0;
        out_wr_data.val  = in_rd_reg;
        out_wr_data.rmax = out_empty ? in_rd_reg
                                     : fwrm_pkg::smax(in_rd_reg, out_top_max_reg);

        if (cmd.exec)
        begin
            head_set_next = 1'b0;
            status_next   = fwrm_pkg::STAT_OK;
            unique case (mode_reg)
                fwrm_pkg::MODE_PUSH:
                begin
                    if (full)
                    begin
                        status_next = fwrm_pkg::STAT_FULL;
                    end
                    else
                    begin
                        in_wr_en        = 1'b1;
                        in_count_next   = in_count_reg + fwrm_pkg::CNT_W'(1);
                        in_top_max_next = in_empty ? value_reg
                                          : fwrm_pkg::smax(value_reg, in_top_max_reg);
                        if (in_empty)
                        begin
                            in_bot_val_next = value_reg;
                        end
                    end
                end
                fwrm_pkg::MODE_POP,
                fwrm_pkg::MODE_QUERY:
                begin
                    if (total == '0)
                    begin
                        status_next = fwrm_pkg::STAT_EMPTY;
                    end
                end
                fwrm_pkg::MODE_CLEAR:
                begin
                    in_count_next  = '0;
                    out_count_next = '0;
                end
                default:
                begin
                    status_next = fwrm_pkg::STAT_OK;
                end
            endcase
        end

        if (cmd.move_rd)
        begin
            in_count_next = in_dec;
        end

        if (cmd.move_wr)
        begin
            out_wr_en        = 1'b1;
            out_count_next   = out_count_reg + fwrm_pkg::CNT_W'(1);
            out_top_val_next = out_wr_data.val;
            out_top_max_next = out_wr_data.rmax;
        end

        if (cmd.pop)
        begin
            head_next      = out_top_val_reg;
            head_set_next  = 1'b1;
            out_count_next = out_count_reg - fwrm_pkg::CNT_W'(1);
        end

        if (cmd.refresh)
        begin
            out_top_val_next = out_rd_reg.val;
            out_top_max_next = out_rd_reg.rmax;
        end

        if (cmd.result_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
            head_set_reg  <= 1'b0;
            status_reg    <= fwrm_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            head_set_reg  <= head_set_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= fwrm_pkg::mode_t'(mode);
            value_reg <= value;
        end
        in_top_max_reg  <= in_top_max_next;
        in_bot_val_reg  <= in_bot_val_next;
        out_top_val_reg <= out_top_val_next;
        out_top_max_reg <= out_top_max_next;
        head_reg        <= head_next;
        if (cmd.result_ld)
        begin
            head_value_reg <= head_set_reg ? head_reg : front;
            max_value_reg  <= qmax;
            count_reg      <= total;
            status_out_reg <= status_reg;
        end
    end

    // memories: one write and one registered read per stack
    always_ff @(posedge clk)
    begin
        if (in_wr_en)
        begin
            in_mem[in_count_reg[fwrm_pkg::ADDR_W-1:0]] <= value_reg;
        end
        if (cmd.move_rd)
        begin
            in_rd_reg <= in_mem[in_dec[fwrm_pkg::ADDR_W-1:0]];
        end
        if (out_wr_en)
        begin
            out_mem[out_count_reg[fwrm_pkg::ADDR_W-1:0]] <= out_wr_data;
        end
        // entry under the one being popped becomes the new top
        if (cmd.pop)
        begin
            out_rd_reg <= out_mem[out_dec2[fwrm_pkg::ADDR_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign head_value = head_value_reg;
    assign max_value  = max_value_reg;
    assign count      = count_reg;
    assign status     = status_out_reg;

endmodule

@@ sv/fwrm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwrm_checker
// Port-level checks on the result channel of the running-max FIFO.
// ----------------------------------------------------------------------------
module fwrm_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [fwrm_pkg::DATA_W-1:0]   head_value,
    input  logic signed [fwrm_pkg::DATA_W-1:0]   max_value,
    input  logic [fwrm_pkg::CNT_W-1:0]           count,
    input  logic [1:0]                           status
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(head_value)
            && $stable(max_value) && $stable(count) && $stable(status))
        else $error("result word changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fwrm_pkg::STAT_FULL
            |-> count == fwrm_pkg::CNT_W'(fwrm_pkg::DEPTH))
        else $error("full status with count below depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fwrm_pkg::STAT_EMPTY
            |-> count == '0 && head_value == '1)
        else $error("empty status with nonzero count or front");

    // a pop that empties the queue still shows the popped word as head
    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count == '0 |-> max_value == '1)
        else $error("empty queue must report -1 maximum");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= fwrm_pkg::CNT_W'(fwrm_pkg::DEPTH)
            && (status == fwrm_pkg::STAT_OK || status == fwrm_pkg::STAT_EMPTY
                || status == fwrm_pkg::STAT_FULL))
        else $error("count above depth or undefined status code");

endmodule

bind fifo_with_running_max fwrm_checker u_fwrm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head_value (head_value),
    .max_value  (max_value),
    .count      (count),
    .status     (status)
);
